FILE: src/ppi_pkg.sv
// Package: transaction types, status codes and fixed-point helpers for the plane intersection.
`timescale 1ns / 1ps
package ppi_pkg;
	localparam int FracBitsDef = 16;
	localparam int DATA_W = 32;
	localparam int QUOT_W = 32;
	localparam int WIDE_W = 65;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DEN_ZERO = 2'd1,
		ST_B1_ZERO  = 2'd2,
		ST_SAT      = 2'd3
	} ppi_status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] p1_a;
		logic signed [DATA_W-1:0] p1_b;
		logic signed [DATA_W-1:0] p1_c;
		logic signed [DATA_W-1:0] p1_d;
		logic signed [DATA_W-1:0] p2_a;
		logic signed [DATA_W-1:0] p2_b;
		logic signed [DATA_W-1:0] p2_c;
		logic signed [DATA_W-1:0] p2_d;
	} ppi_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] point_x;
		logic signed [DATA_W-1:0] point_y;
		logic signed [DATA_W-1:0] dir_x;
		logic signed [DATA_W-1:0] dir_y;
		logic signed [DATA_W-1:0] dir_z;
		logic [1:0]               status;
	} ppi_out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] dir_x;
		logic signed [DATA_W-1:0] dir_y;
		logic signed [DATA_W-1:0] dir_z;
		logic                     dir_sat;
		logic                     den_zero;
		logic                     b1_zero;
		logic signed [DATA_W-1:0] a1;
		logic signed [DATA_W-1:0] b1;
		logic signed [DATA_W-1:0] d1;
		logic signed [DATA_W-1:0] x0;
		logic                     x_sat;
		logic                     neg;
	} ppi_side_t;

	// {sat, value}: clamp a wide signed value to 32 bits
	function automatic logic [DATA_W:0] clamp_wide(input logic signed [WIDE_W-1:0] v);
		logic [DATA_W:0] r;
		if (v > WIDE_W'(64'sh7FFF_FFFF)) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -WIDE_W'(64'sh8000_0000)) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [WIDE_W-1:0] abs_wide(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] r;
		r = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		return r;
	endfunction

	// {sat, value}: apply sign to an unsigned quotient and clamp
	function automatic logic [DATA_W:0] quot_final(input logic ovf, input logic neg,
			input logic [QUOT_W-1:0] q);
		logic [DATA_W:0] r;
		logic signed [WIDE_W-1:0] v;
		v = neg ? -WIDE_W'({1'b0, q}) : WIDE_W'({1'b0, q});
		if (ovf) begin
			r = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
		end else begin
			r = clamp_wide(v);
		end
		return r;
	endfunction
endpackage

FILE: src/ppi_udiv.sv
// Pipelined restoring divider: one quotient bit per stage, overflow flag, sideband.
`timescale 1ns / 1ps
module ppi_udiv import ppi_pkg::*; #(
	parameter int NUM_W  = 81,
	parameter int DEN_W  = 64,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [QUOT_W-1:0] quot,
	output logic              ovf,
	output logic [SIDE_W-1:0] side_out
);
	localparam int CMP_W = NUM_W + DEN_W + QUOT_W;

	logic              vld_s  [0:QUOT_W];
	logic [DEN_W-1:0]  rem_s  [0:QUOT_W];
	logic [DEN_W-1:0]  den_s  [0:QUOT_W];
	logic [QUOT_W-1:0] lo_s   [0:QUOT_W];
	logic [QUOT_W-1:0] q_s    [0:QUOT_W];
	logic              ovf_s  [0:QUOT_W];
	logic [SIDE_W-1:0] side_s [0:QUOT_W];

	logic [NUM_W-1:0] num_hi;
	logic [CMP_W-1:0] num_ext, den_ext;

	assign num_hi  = num >> QUOT_W;
	assign num_ext = CMP_W'(num);
	assign den_ext = CMP_W'(den) << QUOT_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_hi[DEN_W-1:0];
			den_s[0]  <= den;
			lo_s[0]   <= num[QUOT_W-1:0];
			q_s[0]    <= '0;
			ovf_s[0]  <= (num_ext >= den_ext);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
		logic [DEN_W:0] trial, diff;
		logic           ge;
		assign trial = {rem_s[k-1], lo_s[k-1][QUOT_W-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_s[k]  <= den_s[k-1];
				lo_s[k]   <= {lo_s[k-1][QUOT_W-2:0], 1'b0};
				q_s[k]    <= {q_s[k-1][QUOT_W-2:0], ge};
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[QUOT_W];
	assign quot     = q_s[QUOT_W];
	assign ovf      = ovf_s[QUOT_W];
	assign side_out = side_s[QUOT_W];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[QUOT_W] && !ovf_s[QUOT_W]) |-> (rem_s[QUOT_W] < den_s[QUOT_W]))
		else $error("divider remainder not below divisor");

	a_zero_den_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[QUOT_W] && !ovf_s[QUOT_W]) |-> (den_s[QUOT_W] != '0))
		else $error("zero divisor without overflow flag");

	a_hold_out_vld: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[QUOT_W]))
		else $error("divider output valid moved during stall");
endmodule

FILE: src/plane_plane_intersection_top.sv
// Throughput: one transaction per cycle while the output is not stalled; two 33-stage divider pipelines set the depth.
// Stall: the whole pipeline holds while a result waits at the output register.
// Reset: arst_n clears all valid bits; data registers are not reset.
// Top level: plane pair to intersection line, deep pipeline.
`timescale 1ns / 1ps
module plane_plane_intersection_top import ppi_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ppi_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ppi_out_t out_data
);
	localparam int NUMX_W = WIDE_W + FRAC_BITS;
	localparam int SIDE_W = $bits(ppi_side_t);

	logic en;
	logic out_valid_q;
	ppi_out_t out_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: products
	logic vld_s1;
	logic signed [63:0] ab_s1, ba_s1, bc_s1, cb_s1, ca_s1, ac_s1, db_s1, bd_s1;
	logic signed [DATA_W-1:0] a1_s1, b1_s1, d1_s1;
	// stage 2: differences
	logic vld_s2;
	logic signed [WIDE_W-1:0] den_s2, cx_s2, cy_s2, num_s2;
	logic signed [DATA_W-1:0] a1_s2, b1_s2, d1_s2;
	// stage 3: direction, magnitudes
	logic vld_s3;
	logic [NUMX_W-1:0] numx_s3;
	logic [63:0] denx_s3;
	ppi_side_t side_s3;
	logic [WIDE_W-1:0] den_abs;

	logic xd_vld;
	logic [QUOT_W-1:0] xd_q;
	logic xd_ovf;
	logic [SIDE_W-1:0] xd_side;
	ppi_side_t xd_sd;
	logic [DATA_W:0] x_fin;
	ppi_side_t side_x;

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	ppi_side_t side_s4, side_s5, side_s6, side_s7;
	logic signed [63:0] ax_s5;
	logic signed [WIDE_W-1:0] num2_s6;
	logic [WIDE_W-1:0] numy_s7;
	logic [DATA_W-1:0] deny_s7;
	ppi_side_t side_y;

	logic yd_vld;
	logic [QUOT_W-1:0] yd_q;
	logic yd_ovf;
	logic [SIDE_W-1:0] yd_side;
	ppi_side_t yd_sd;
	logic [DATA_W:0] y_fin;
	ppi_out_t out_d;

	logic [DATA_W:0] cl_x, cl_y, cl_z;
	logic signed [WIDE_W-1:0] den_sh, cx_sh, cy_sh, num2_abs_in;
	logic signed [DATA_W:0] b1_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= xd_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			out_valid_q <= yd_vld;
		end
	end

	assign cx_sh   = cx_s2 >>> FRAC_BITS;
	assign cy_sh   = cy_s2 >>> FRAC_BITS;
	assign den_sh  = den_s2 >>> FRAC_BITS;
	assign cl_x    = clamp_wide(cx_sh);
	assign cl_y    = clamp_wide(cy_sh);
	assign cl_z    = clamp_wide(den_sh);
	assign den_abs = abs_wide(den_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s1 <= in_data.p1_a * in_data.p2_b;
			ba_s1 <= in_data.p2_a * in_data.p1_b;
			bc_s1 <= in_data.p1_b * in_data.p2_c;
			cb_s1 <= in_data.p1_c * in_data.p2_b;
			ca_s1 <= in_data.p1_c * in_data.p2_a;
			ac_s1 <= in_data.p1_a * in_data.p2_c;
			db_s1 <= in_data.p2_d * in_data.p1_b;
			bd_s1 <= in_data.p1_d * in_data.p2_b;
			a1_s1 <= in_data.p1_a;
			b1_s1 <= in_data.p1_b;
			d1_s1 <= in_data.p1_d;

			den_s2 <= WIDE_W'(ab_s1) - WIDE_W'(ba_s1);
			cx_s2  <= WIDE_W'(bc_s1) - WIDE_W'(cb_s1);
			cy_s2  <= WIDE_W'(ca_s1) - WIDE_W'(ac_s1);
			num_s2 <= WIDE_W'(db_s1) - WIDE_W'(bd_s1);
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			d1_s2  <= d1_s1;

			numx_s3          <= NUMX_W'(abs_wide(num_s2)) << FRAC_BITS;
			denx_s3          <= den_abs[63:0];
			side_s3.dir_x    <= cl_x[DATA_W-1:0];
			side_s3.dir_y    <= cl_y[DATA_W-1:0];
			side_s3.dir_z    <= cl_z[DATA_W-1:0];
			side_s3.dir_sat  <= cl_x[DATA_W] | cl_y[DATA_W] | cl_z[DATA_W];
			side_s3.den_zero <= (den_s2 == '0);
			side_s3.b1_zero  <= (b1_s2 == '0);
			side_s3.a1       <= a1_s2;
			side_s3.b1       <= b1_s2;
			side_s3.d1       <= d1_s2;
			side_s3.x0       <= '0;
			side_s3.x_sat    <= 1'b0;
			side_s3.neg      <= num_s2[WIDE_W-1] ^ den_s2[WIDE_W-1];
		end
	end

	ppi_udiv #(
		.NUM_W  (NUMX_W),
		.DEN_W  (64),
		.SIDE_W (SIDE_W)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.num      (numx_s3),
		.den      (denx_s3),
		.side_in  (side_s3),
		.out_vld  (xd_vld),
		.quot     (xd_q),
		.ovf      (xd_ovf),
		.side_out (xd_side)
	);

	assign xd_sd = ppi_side_t'(xd_side);
	assign x_fin = quot_final(xd_ovf, xd_sd.neg, xd_q);
	assign num2_abs_in = -(WIDE_W'(side_s5.d1) <<< FRAC_BITS) - WIDE_W'(ax_s5);
	assign b1_wide = side_s6.b1[DATA_W-1] ? -(DATA_W+1)'(side_s6.b1) : (DATA_W+1)'(side_s6.b1);

	always_comb begin
		side_x       = xd_sd;
		side_x.x0    = x_fin[DATA_W-1:0];
		side_x.x_sat = x_fin[DATA_W];
	end

	always_comb begin
		side_y     = side_s6;
		side_y.neg = num2_s6[WIDE_W-1] ^ side_s6.b1[DATA_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_x;

			ax_s5   <= side_s4.a1 * side_s4.x0;
			side_s5 <= side_s4;

			num2_s6 <= num2_abs_in;
			side_s6 <= side_s5;

			numy_s7 <= abs_wide(num2_s6);
			deny_s7 <= b1_wide[DATA_W-1:0];
			side_s7 <= side_y;
		end
	end

	ppi_udiv #(
		.NUM_W  (WIDE_W),
		.DEN_W  (DATA_W),
		.SIDE_W (SIDE_W)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.num      (numy_s7),
		.den      (deny_s7),
		.side_in  (side_s7),
		.out_vld  (yd_vld),
		.quot     (yd_q),
		.ovf      (yd_ovf),
		.side_out (yd_side)
	);

	assign yd_sd = ppi_side_t'(yd_side);
	assign y_fin = quot_final(yd_ovf, yd_sd.neg, yd_q);

	always_comb begin
		out_d = '0;
		if (yd_sd.den_zero) begin
			out_d.status = ST_DEN_ZERO;
		end else if (yd_sd.b1_zero) begin
			out_d.status = ST_B1_ZERO;
		end else begin
			out_d.point_x = yd_sd.x0;
			out_d.point_y = y_fin[DATA_W-1:0];
			out_d.dir_x   = yd_sd.dir_x;
			out_d.dir_y   = yd_sd.dir_y;
			out_d.dir_z   = yd_sd.dir_z;
			out_d.status  = (yd_sd.dir_sat | yd_sd.x_sat | y_fin[DATA_W]) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == ST_DEN_ZERO || out_data.status == ST_B1_ZERO))
		|-> (out_data.point_x == '0 && out_data.point_y == '0 && out_data.dir_x == '0
			&& out_data.dir_y == '0 && out_data.dir_z == '0))
		else $error("flagged result carries nonzero fields");

	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked without a pending result");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_s3) |=> vld_s3)
		else $error("pipeline stage dropped a transaction during stall");
endmodule
